// File: design/bsa_pkg.sv
// Package: types and constants for the bilinear splat accumulator.
package bsa_pkg;

  localparam int MaxSideDef = 256;
  localparam int AccBitsDef = 40;
  localparam int OutBits    = 40;
  localparam int SideCfgBits = 9;

  typedef enum logic [1:0] {
    KIND_SPLAT = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_CLEAR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic [15:0]        color_red;
    logic [15:0]        color_green;
    logic [15:0]        color_blue;
    logic [15:0]        sample_weight;
    logic [7:0]         read_col;
    logic [7:0]         read_row;
  } in_item_t;

  typedef struct packed {
    logic [OutBits-1:0] red_sum;
    logic [OutBits-1:0] green_sum;
    logic [OutBits-1:0] blue_sum;
    logic [OutBits-1:0] weight_sum;
    logic [2:0]         corners_written;
  } out_item_t;

endpackage

// File: design/bsa_ram.sv
// Generic single-port RAM with registered read.
module bsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: design/bilinear_splat_accumulator_unit.sv
// Top level: bilinear splat accumulation image with read-modify-write pixel memory.
//
//  channel | handshake        | payload
//  in_     | in_valid/in_stall  | bsa_pkg::in_item_t
//  out_    | out_valid/out_stall| bsa_pkg::out_item_t
//  cfg_    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A splat is accepted, then each corner gets a read and a write back, and a last step
// loads the result register; a read and a clear likewise end in that step.
// After reset the memory is cleared one pixel a cycle while no item is taken.
// A stalled result holds in its register; the next item runs meanwhile and waits
// in ST_OUT until the register frees.
module bilinear_splat_accumulator_unit #(
  parameter int MAX_SIDE = bsa_pkg::MaxSideDef,
  parameter int ACC_BITS = bsa_pkg::AccBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bsa_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bsa_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [8:0]          cfg_data
);
  import bsa_pkg::*;

  localparam int SideBits = $clog2(MAX_SIDE);
  localparam int AddrBits = 2 * SideBits;
  localparam int Depth    = 1 << AddrBits;
  localparam int WBits    = 4 * ACC_BITS;
  localparam int SumBits  = ((ACC_BITS > 33) ? ACC_BITS : 33) + 1;
  localparam logic [ACC_BITS-1:0] AccMax = {ACC_BITS{1'b1}};
  localparam logic [12:0] MaxSide13 = 13'(MAX_SIDE);

  state_t state_r, state_nxt;
  logic [AddrBits-1:0] addr_r, addr_nxt;
  logic [1:0] corner_r, corner_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  in_item_t item_r, item_nxt;
  out_item_t res_r, res_nxt;
  out_item_t ores_r, ores_nxt;
  logic ovld_r, ovld_nxt;
  logic [SideCfgBits-1:0] wd_r, ht_r;
  logic [12:0] eff_w, eff_h;
  logic [16:0] cw_r, cw_nxt;
  logic cin_r, cin_nxt;
  logic we;
  logic [AddrBits-1:0] ram_addr;
  logic [WBits-1:0] wdata, rdata;

  bsa_ram #(.Width(WBits), .Depth(Depth)) u_ram (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign eff_w = (13'(wd_r) > MaxSide13) ? MaxSide13 : 13'(wd_r);
  assign eff_h = (13'(ht_r) > MaxSide13) ? MaxSide13 : 13'(ht_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_r <= 9'd256;
      ht_r <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  wd_r <= cfg_data;
        CFG_HEIGHT: ht_r <= cfg_data;
        default:    wd_r <= wd_r;
      endcase
    end
  end

  // corner geometry
  logic signed [12:0] ax, ay, cx, cy;
  logic [8:0] tx, ty, ux, uy, fx, fy;
  logic [16:0] cw;
  logic cin;
  always_comb begin
    ax = 13'(signed'(item_r.pos_x[19:8]));
    ay = 13'(signed'(item_r.pos_y[19:8]));
    tx = {1'b0, item_r.pos_x[7:0]};
    ty = {1'b0, item_r.pos_y[7:0]};
    ux = 9'd256 - tx;
    uy = 9'd256 - ty;
    cx = (corner_r == 2'd1 || corner_r == 2'd2) ? ax + 13'sd1 : ax;
    cy = (corner_r[1]) ? ay + 13'sd1 : ay;
    fx = (corner_r == 2'd1 || corner_r == 2'd2) ? tx : ux;
    fy = (corner_r[1]) ? ty : uy;
    cw = 17'(fx * fy);
    cin = !cx[12] && !cy[12] && (cx < signed'(eff_w)) && (cy < signed'(eff_h));
  end

  // saturating accumulate
  function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                  input logic [32:0] b);
    logic [SumBits-1:0] s;
    s = SumBits'(a) + SumBits'(b);
    return (s > SumBits'(AccMax)) ? AccMax : s[ACC_BITS-1:0];
  endfunction

  logic [32:0] p0, p1, p2, p3;
  always_comb begin
    p0 = 33'(cw_r * item_r.color_red);
    p1 = 33'(cw_r * item_r.color_green);
    p2 = 33'(cw_r * item_r.color_blue);
    p3 = 33'(cw_r * item_r.sample_weight);
    wdata = {sat_add(rdata[4*ACC_BITS-1:3*ACC_BITS], p0),
             sat_add(rdata[3*ACC_BITS-1:2*ACC_BITS], p1),
             sat_add(rdata[2*ACC_BITS-1:ACC_BITS], p2),
             sat_add(rdata[ACC_BITS-1:0], p3)};
    if (state_r == ST_INIT || state_r == ST_CLEAR) begin
      wdata = '0;
    end
  end

  logic [AddrBits-1:0] caddr;
  assign caddr = {cy[SideBits-1:0], cx[SideBits-1:0]};

  always_comb begin
    state_nxt = state_r;
    addr_nxt = addr_r;
    corner_nxt = corner_r;
    cnt_nxt = cnt_r;
    item_nxt = item_r;
    res_nxt = res_r;
    cw_nxt = cw_r;
    cin_nxt = cin_r;
    ores_nxt = ores_r;
    ovld_nxt = ovld_r;
    if (ovld_r && !out_stall) begin
      ovld_nxt = 1'b0;
    end
    we = 1'b0;
    ram_addr = addr_r;
    in_stall = 1'b1;
    case (state_r)
      ST_INIT, ST_CLEAR: begin
        we = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == {AddrBits{1'b1}}) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_OUT;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          item_nxt = in_item;
          res_nxt = '0;
          corner_nxt = 2'd0;
          cnt_nxt = '0;
          addr_nxt = '0;
          case (kind_t'(in_item.kind))
            KIND_SPLAT: state_nxt = ST_RD;
            KIND_READ: begin
              ram_addr = {SideBits'(in_item.read_row), SideBits'(in_item.read_col)};
              state_nxt = ST_WR;
            end
            KIND_CLEAR: state_nxt = ST_CLEAR;
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_RD: begin
        ram_addr = caddr;
        addr_nxt = caddr;
        cw_nxt = cw;
        cin_nxt = cin;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        if (kind_t'(item_r.kind) == KIND_READ) begin
          if (13'(item_r.read_col) < eff_w && 13'(item_r.read_row) < eff_h) begin
            res_nxt.red_sum = OutBits'(rdata[4*ACC_BITS-1:3*ACC_BITS]);
            res_nxt.green_sum = OutBits'(rdata[3*ACC_BITS-1:2*ACC_BITS]);
            res_nxt.blue_sum = OutBits'(rdata[2*ACC_BITS-1:ACC_BITS]);
            res_nxt.weight_sum = OutBits'(rdata[ACC_BITS-1:0]);
          end
          state_nxt = ST_OUT;
        end else begin
          we = cin_r;
          cnt_nxt = cnt_r + 3'(cin_r);
          corner_nxt = corner_r + 2'd1;
          if (corner_r == 2'd3) begin
            res_nxt.corners_written = cnt_r + 3'(cin_r);
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_OUT: begin
        if (!ovld_r || !out_stall) begin
          ovld_nxt = 1'b1;
          ores_nxt = res_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      addr_r <= '0;
      corner_r <= '0;
      cnt_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r <= addr_nxt;
      corner_r <= corner_nxt;
      cnt_r <= cnt_nxt;
      ovld_r <= ovld_nxt;
    end
    item_r <= item_nxt;
    res_r <= res_nxt;
    ores_r <= ores_nxt;
    cw_r <= cw_nxt;
    cin_r <= cin_nxt;
  end

  assign out_valid = ovld_r;
  assign out_item = ores_r;
endmodule

// File: design/bsa_checker.sv
// Port-level assertions for the splat accumulator, bound to the top level.
module bsa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bsa_pkg::out_item_t out_item
);
  import bsa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_corners_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.corners_written <= 3'd4)
    else $error("corner count above four");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken in cycle after accept");

  a_sums_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.corners_written != 3'd0 |->
      out_item.red_sum == '0 && out_item.weight_sum == '0)
    else $error("splat result carries sums");
endmodule

bind bilinear_splat_accumulator_unit bsa_checker u_bsa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
